FILE: hw/rtl/lctw_pkg.sv
// ============================================================================
// Load-cell averaging scale: shared definitions
// Widths, reset values, register indexes, reciprocal constants and the
// structures that travel between the blocks of the scale datapath.
// ============================================================================
`default_nettype none

package lctw_pkg;

    // Window and sample format
    localparam int SAMPLES_PER_WINDOW = 30;
    localparam int SAMPLE_BITS        = 12;
    localparam int COUNT_BITS         = $clog2(SAMPLES_PER_WINDOW);
    localparam int SUM_BITS           = SAMPLE_BITS + $clog2(SAMPLES_PER_WINDOW);

    // Field widths
    localparam int AVG_BITS     = 12;
    localparam int WEIGHT_BITS  = 19;
    localparam int GAIN_BITS    = 10;
    localparam int OFFSET_BITS  = 16;
    localparam int DEAD_BITS    = 12;
    localparam int MARGIN_BITS  = 8;
    localparam int NET_BITS     = AVG_BITS + 1;
    localparam int PROD_BITS    = GAIN_BITS + AVG_BITS;
    localparam int VALUE_BITS   = PROD_BITS + 1;

    // Stream and register port widths
    localparam int S_TDATA_BITS = 16;
    localparam int M_TDATA_BITS = 32;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 4;

    // Register reset values
    localparam logic [GAIN_BITS-1:0]   GAIN_RESET        = GAIN_BITS'(438);
    localparam logic [OFFSET_BITS-1:0] OFFSET_RESET      = OFFSET_BITS'(3601);
    localparam logic [DEAD_BITS-1:0]   DEAD_BAND_RESET   = DEAD_BITS'(20);
    localparam logic [MARGIN_BITS-1:0] TARE_MARGIN_RESET = MARGIN_BITS'(7);

    // Average: sum / SAMPLES_PER_WINDOW as a multiply by a rounded-up reciprocal
    localparam int AVG_DIV_SHIFT = 24;
    localparam longint AVG_DIV_MULT =
        ((64'd1 << AVG_DIV_SHIFT) + SAMPLES_PER_WINDOW - 1) / SAMPLES_PER_WINDOW;
    localparam int AVG_MULT_BITS = $clog2(AVG_DIV_MULT + 1);
    localparam int AVG_PROD_BITS = SUM_BITS + AVG_MULT_BITS;

    // Weight scaling: magnitude / 10 as a multiply by a rounded-up reciprocal
    localparam int WEIGHT_DIVISOR = 10;
    localparam int WEIGHT_BIAS    = 10;
    localparam int DIV10_SHIFT    = 26;
    localparam longint DIV10_MULT =
        ((64'd1 << DIV10_SHIFT) + WEIGHT_DIVISOR - 1) / WEIGHT_DIVISOR;
    localparam int DIV10_MULT_BITS = $clog2(DIV10_MULT + 1);
    localparam int DIV10_PROD_BITS = PROD_BITS + DIV10_MULT_BITS;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_GAIN        = 2'd0,
        REG_OFFSET      = 2'd1,
        REG_DEAD_BAND   = 2'd2,
        REG_TARE_MARGIN = 2'd3
    } reg_index_t;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [GAIN_BITS-1:0]   gain;
        logic [OFFSET_BITS-1:0] offset_count;
        logic [DEAD_BITS-1:0]   dead_band;
        logic [MARGIN_BITS-1:0] tare_margin;
    } cfg_t;

    // One closed window, passed from the accumulator to the weigh pipeline
    typedef struct packed {
        logic [AVG_BITS-1:0] avg;
        logic                tare_req;
    } avg_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/load_cell_average_tare_weigh.sv
// ============================================================================
// Load-cell averaging scale with tare capture
// Averages windows of 30 ADC samples and reports either a weight or a new
// tare for each closed window.
// ============================================================================
// The block takes one 12-bit sample per cycle on the slave stream and emits
// one result per window of 30 samples on the master stream. The func flag of
// the window's last sample selects the result: 1 stores the average less the
// tare margin (clamped at zero) as the new tare and reports zero weight, 0
// reports the weight from the net count above the tare. After the sample that
// closes its window, two stages form the average with a reciprocal multiply,
// then the gain product, the offset subtraction, the divide by ten and the
// final clamp each take one registered stage. Every stage holds its item under
// back-pressure, so samples keep flowing while a result waits; only the
// window-closing sample waits when the pipeline is full. Registers are to
// be written over the APB port only while the block is idle (not enforced).
`default_nettype none

module load_cell_average_tare_weigh (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [lctw_pkg::S_TDATA_BITS-1:0]  s_tdata,   // [11:0] sample
    input  wire logic                               s_tuser,   // [0] func
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [lctw_pkg::M_TDATA_BITS-1:0]  m_tdata,   // [18:0] weight,
                                                               // [30:19] average
    output logic                                    m_tuser,   // [0] tare_updated
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [lctw_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [lctw_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic      [lctw_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                    pready
);
    import lctw_pkg::*;

    cfg_t      cfg;
    logic      avg_valid;
    logic      avg_ready;
    avg_item_t avg_item;

    // Configuration registers.
    lctw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Window sum and average.
    lctw_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .avg_valid (avg_valid),
        .avg_ready (avg_ready),
        .avg_item  (avg_item)
    );

    // Tare, weight conversion and result stream.
    lctw_weigh u_weigh (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .avg_valid (avg_valid),
        .avg_ready (avg_ready),
        .avg_item  (avg_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/lctw_regs.sv
// ============================================================================
// Load-cell scale configuration registers
// APB-style register file for gain, offset, dead band and tare margin.
// ============================================================================
`default_nettype none

module lctw_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [lctw_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [lctw_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic      [lctw_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                    pready,
    output lctw_pkg::cfg_t                          cfg
);
    import lctw_pkg::*;

    cfg_t       cfg_reg;
    reg_index_t reg_index;
    logic       write_en;

    assign reg_index = reg_index_t'(paddr[3:2]);
    assign write_en  = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    // Register writes on the access phase of a write transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain         <= GAIN_RESET;
            cfg_reg.offset_count <= OFFSET_RESET;
            cfg_reg.dead_band    <= DEAD_BAND_RESET;
            cfg_reg.tare_margin  <= TARE_MARGIN_RESET;
        end
        else if (write_en)
        begin
            unique case (reg_index)
                REG_GAIN:        cfg_reg.gain         <= pwdata[GAIN_BITS-1:0];
                REG_OFFSET:      cfg_reg.offset_count <= pwdata[OFFSET_BITS-1:0];
                REG_DEAD_BAND:   cfg_reg.dead_band    <= pwdata[DEAD_BITS-1:0];
                REG_TARE_MARGIN: cfg_reg.tare_margin  <= pwdata[MARGIN_BITS-1:0];
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        unique case (reg_index)
            REG_GAIN:        prdata = APB_DATA_BITS'(cfg_reg.gain);
            REG_OFFSET:      prdata = APB_DATA_BITS'(cfg_reg.offset_count);
            REG_DEAD_BAND:   prdata = APB_DATA_BITS'(cfg_reg.dead_band);
            REG_TARE_MARGIN: prdata = APB_DATA_BITS'(cfg_reg.tare_margin);
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lctw_accum.sv
// ============================================================================
// Load-cell scale window accumulator
// Sums samples over one window, then forms the window average with a
// reciprocal multiply in a two-stage registered path.
// ============================================================================
`default_nettype none

module lctw_accum (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [lctw_pkg::S_TDATA_BITS-1:0] s_tdata,   // [11:0] sample
    input  wire logic                              s_tuser,   // [0] func
    output logic                                   avg_valid,
    input  wire logic                              avg_ready,
    output lctw_pkg::avg_item_t                    avg_item
);
    import lctw_pkg::*;

    logic [SUM_BITS-1:0]      sum_reg;
    logic [COUNT_BITS-1:0]    count_reg;
    logic [SUM_BITS-1:0]      sum_next;
    logic                     window_last;
    logic                     in_fire;

    logic                     p1_valid_reg;
    logic [SUM_BITS-1:0]      p1_sum_reg;
    logic                     p1_tare_reg;
    logic                     p1_ready;

    logic                     p2_valid_reg;
    avg_item_t                p2_item_reg;
    logic                     p2_ready;
    logic [AVG_PROD_BITS-1:0] avg_prod;

    // Handshake chain: each stage moves when the next one is empty or moving.
    assign p2_ready    = !p2_valid_reg || avg_ready;
    assign p1_ready    = !p1_valid_reg || p2_ready;
    assign window_last = (count_reg == COUNT_BITS'(SAMPLES_PER_WINDOW - 1));
    assign s_tready    = !window_last || p1_ready;
    assign in_fire     = s_tvalid && s_tready;
    assign sum_next    = sum_reg + SUM_BITS'(s_tdata[SAMPLE_BITS-1:0]);

    // Running sum and sample count of the open window.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (in_fire)
        begin
            if (window_last)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
            end
            else
            begin
                sum_reg   <= sum_next;
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Closed-window sum stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (p1_ready)
            p1_valid_reg <= in_fire && window_last;
    end

    always_ff @(posedge clk)
    begin
        if (p1_ready && in_fire && window_last)
        begin
            p1_sum_reg  <= sum_next;
            p1_tare_reg <= s_tuser;
        end
    end

    // Average: floor(sum / window) through the rounded-up reciprocal.
    assign avg_prod = AVG_PROD_BITS'(p1_sum_reg) *
                      AVG_PROD_BITS'(AVG_DIV_MULT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else if (p2_ready)
            p2_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (p2_ready && p1_valid_reg)
        begin
            p2_item_reg.avg      <= avg_prod[AVG_DIV_SHIFT +: AVG_BITS];
            p2_item_reg.tare_req <= p1_tare_reg;
        end
    end

    assign avg_valid = p2_valid_reg;
    assign avg_item  = p2_item_reg;

`ifndef SYNTHESIS
    // The window count never runs past the last sample of a window.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_BITS'(SAMPLES_PER_WINDOW - 1))
        else $error("sample count out of range");

    // The running sum never exceeds what the samples taken so far can add up to.
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(sum_reg) <= int'(count_reg) * ((2 ** SAMPLE_BITS) - 1))
        else $error("running sum exceeds its bound");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/lctw_weigh.sv
// ============================================================================
// Load-cell scale weigh pipeline
// Holds the tare, forms the net count, applies gain and offset, scales by
// one tenth, clamps, and drives the result stream from an output register.
// ============================================================================
`default_nettype none

module lctw_weigh (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire lctw_pkg::cfg_t                    cfg,
    input  wire logic                              avg_valid,
    output logic                                   avg_ready,
    input  wire lctw_pkg::avg_item_t               avg_item,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [lctw_pkg::M_TDATA_BITS-1:0] m_tdata,   // [18:0] weight,
                                                              // [30:19] average
    output logic                                   m_tuser    // [0] tare_updated
);
    import lctw_pkg::*;

    logic [AVG_BITS-1:0]        tare_reg;
    logic [AVG_BITS-1:0]        tare_next;
    logic signed [NET_BITS-1:0] net;
    logic                       in_dead_band;
    logic [PROD_BITS-1:0]       gain_prod;
    logic                       avg_fire;

    // Product stage
    logic                       p3_valid_reg;
    logic [PROD_BITS-1:0]       p3_prod_reg;
    logic                       p3_blank_reg;
    logic                       p3_tare_reg;
    logic [AVG_BITS-1:0]        p3_avg_reg;
    logic                       p3_ready;

    // Offset and magnitude stage
    logic                       p4_valid_reg;
    logic [PROD_BITS-1:0]       p4_mag_reg;
    logic                       p4_neg_reg;
    logic                       p4_blank_reg;
    logic                       p4_tare_reg;
    logic [AVG_BITS-1:0]        p4_avg_reg;
    logic                       p4_ready;
    logic [VALUE_BITS-1:0]      value;
    logic [VALUE_BITS-1:0]      value_abs;

    // Divide-by-ten stage
    logic                       p5_valid_reg;
    logic [WEIGHT_BITS-1:0]     p5_quot_reg;
    logic                       p5_neg_reg;
    logic                       p5_blank_reg;
    logic                       p5_tare_reg;
    logic [AVG_BITS-1:0]        p5_avg_reg;
    logic                       p5_ready;
    logic [DIV10_PROD_BITS-1:0] div_prod;

    // Output register
    logic                       out_valid_reg;
    logic [WEIGHT_BITS-1:0]     out_weight_reg;
    logic [AVG_BITS-1:0]        out_avg_reg;
    logic                       out_tare_reg;
    logic [WEIGHT_BITS:0]       weight_up;
    logic [WEIGHT_BITS-1:0]     weight_next;

    assign p5_ready  = !out_valid_reg || m_tready;
    assign p4_ready  = !p5_valid_reg || p5_ready;
    assign p3_ready  = !p4_valid_reg || p4_ready;
    assign avg_ready = p3_ready;
    assign avg_fire  = avg_valid && avg_ready;

    // Net count against the stored tare, dead-band test and gain product.
    assign net          = $signed({1'b0, avg_item.avg}) - $signed({1'b0, tare_reg});
    assign in_dead_band = (net <= $signed({1'b0, cfg.dead_band}));
    assign gain_prod    = PROD_BITS'(cfg.gain) * PROD_BITS'(net[AVG_BITS-1:0]);

    // New tare: average less the margin, clamped at zero.
    assign tare_next = (avg_item.avg > AVG_BITS'(cfg.tare_margin)) ?
                       (avg_item.avg - AVG_BITS'(cfg.tare_margin)) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tare_reg <= '0;
        else if (avg_fire && avg_item.tare_req)
            tare_reg <= tare_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_valid_reg <= 1'b0;
        else if (p3_ready)
            p3_valid_reg <= avg_valid;
    end

    always_ff @(posedge clk)
    begin
        if (avg_fire)
        begin
            p3_prod_reg  <= gain_prod;
            p3_blank_reg <= avg_item.tare_req || in_dead_band;
            p3_tare_reg  <= avg_item.tare_req;
            p3_avg_reg   <= avg_item.avg;
        end
    end

    // Subtract the offset and split the signed value into sign and magnitude.
    assign value     = VALUE_BITS'(p3_prod_reg) - VALUE_BITS'(cfg.offset_count);
    assign value_abs = value[VALUE_BITS-1] ? (~value + 1'b1) : value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p4_valid_reg <= 1'b0;
        else if (p4_ready)
            p4_valid_reg <= p3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (p4_ready && p3_valid_reg)
        begin
            p4_mag_reg   <= value_abs[PROD_BITS-1:0];
            p4_neg_reg   <= value[VALUE_BITS-1];
            p4_blank_reg <= p3_blank_reg;
            p4_tare_reg  <= p3_tare_reg;
            p4_avg_reg   <= p3_avg_reg;
        end
    end

    // Magnitude divided by ten through the rounded-up reciprocal.
    assign div_prod = DIV10_PROD_BITS'(p4_mag_reg) * DIV10_PROD_BITS'(DIV10_MULT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p5_valid_reg <= 1'b0;
        else if (p5_ready)
            p5_valid_reg <= p4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (p5_ready && p4_valid_reg)
        begin
            p5_quot_reg  <= div_prod[DIV10_SHIFT +: WEIGHT_BITS];
            p5_neg_reg   <= p4_neg_reg;
            p5_blank_reg <= p4_blank_reg;
            p5_tare_reg  <= p4_tare_reg;
            p5_avg_reg   <= p4_avg_reg;
        end
    end

    // Add the bias with the sign restored, clamp at zero and at full scale.
    assign weight_up = (WEIGHT_BITS + 1)'(p5_quot_reg) + (WEIGHT_BITS + 1)'(WEIGHT_BIAS);

    always_comb
    begin
        if (p5_blank_reg)
            weight_next = '0;
        else if (p5_neg_reg)
        begin
            if (p5_quot_reg > WEIGHT_BITS'(WEIGHT_BIAS))
                weight_next = '0;
            else
                weight_next = WEIGHT_BITS'(WEIGHT_BIAS) - p5_quot_reg;
        end
        else if (weight_up[WEIGHT_BITS])
            weight_next = '1;
        else
            weight_next = weight_up[WEIGHT_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (p5_ready)
            out_valid_reg <= p5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (p5_ready && p5_valid_reg)
        begin
            out_weight_reg <= weight_next;
            out_avg_reg    <= p5_avg_reg;
            out_tare_reg   <= p5_tare_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_BITS'({out_avg_reg, out_weight_reg});
    assign m_tuser  = out_tare_reg;

`ifndef SYNTHESIS
    // A tare transaction always reports zero weight.
    a_tare_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_tare_reg) |-> (out_weight_reg == '0))
        else $error("tare result with nonzero weight");

    // The stored tare only changes when a tare window enters the pipeline.
    a_tare_write: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(tare_reg) |-> $past(avg_fire && avg_item.tare_req))
        else $error("tare changed without a tare window");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// Load-cell averaging scale testbench
// Streams windows of ADC samples into the scale and checks every window
// result against an internal prediction of average, tare and weight, under
// random idling on both streams and several register settings.
// ============================================================================

module tb_top;

    import lctw_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_GAP      = 18;
    localparam int RANDOM_PHASES      = 4;
    localparam int WINDOWS_PER_PHASE  = 7;
    localparam longint WEIGHT_MAX = (64'd1 << WEIGHT_BITS) - 1;

    // One window result as it leaves the master stream.
    typedef struct packed {
        logic [WEIGHT_BITS-1:0] weight;
        logic [AVG_BITS-1:0]    average;
        logic                   tare_updated;
    } window_result_t;

    // ------------------------------------------------------------------------
    // Tracks the scale's state and the window results still to arrive.
    // ------------------------------------------------------------------------
    class window_result_tracker;
        logic [GAIN_BITS-1:0]   gain;
        logic [OFFSET_BITS-1:0] offset_count;
        logic [DEAD_BITS-1:0]   dead_band;
        logic [MARGIN_BITS-1:0] tare_margin;
        logic [SUM_BITS-1:0]    sample_sum;
        int                     sample_count;
        logic [AVG_BITS-1:0]    tare_level;
        window_result_t         pending_windows[$];
        int                     errors;

        function new();
            gain         = GAIN_RESET;
            offset_count = OFFSET_RESET;
            dead_band    = DEAD_BAND_RESET;
            tare_margin  = TARE_MARGIN_RESET;
            sample_sum   = '0;
            sample_count = 0;
            tare_level   = '0;
            errors       = 0;
        endfunction

        function void set_register(reg_index_t idx, logic [APB_DATA_BITS-1:0] value);
            case (idx)
                REG_GAIN:        gain         = value[GAIN_BITS-1:0];
                REG_OFFSET:      offset_count = value[OFFSET_BITS-1:0];
                REG_DEAD_BAND:   dead_band    = value[DEAD_BITS-1:0];
                REG_TARE_MARGIN: tare_margin  = value[MARGIN_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Accumulates one accepted sample; a closing sample queues its result.
        function void take_sample(logic [SAMPLE_BITS-1:0] sample, logic func);
            logic [AVG_BITS-1:0] avg;
            longint              net;
            longint              scaled;
            longint              grams;
            window_result_t      res;
            sample_sum += sample;
            sample_count++;
            if (sample_count < SAMPLES_PER_WINDOW)
                return;
            avg          = sample_sum / SAMPLES_PER_WINDOW;
            sample_sum   = '0;
            sample_count = 0;
            res.average  = avg;
            if (func) begin
                // Tare capture clamps at zero when the margin exceeds the average.
                tare_level       = (avg > tare_margin) ? avg - tare_margin : '0;
                res.weight       = '0;
                res.tare_updated = 1'b1;
            end
            else begin
                // Net may be negative; the divide truncates toward zero.
                net   = longint'(avg) - longint'(tare_level);
                grams = 0;
                if (net > longint'(dead_band)) begin
                    scaled = longint'(gain) * net - longint'(offset_count);
                    grams  = scaled / WEIGHT_DIVISOR + WEIGHT_BIAS;
                    if (grams < 0)
                        grams = 0;
                    if (grams > WEIGHT_MAX)
                        grams = WEIGHT_MAX;
                end
                res.weight       = grams[WEIGHT_BITS-1:0];
                res.tare_updated = 1'b0;
            end
            pending_windows.push_back(res);
        endfunction

        // Compares one accepted result with the oldest outstanding window.
        function void check_result(window_result_t got);
            window_result_t want;
            if (pending_windows.size() == 0) begin
                $error("unexpected result: weight %0d average %0d tare_updated %0d",
                       got.weight, got.average, got.tare_updated);
                errors++;
                return;
            end
            want = pending_windows.pop_front();
            if (got.weight !== want.weight) begin
                $error("weight mismatch: expected %0d, actual %0d", want.weight, got.weight);
                errors++;
            end
            if (got.average !== want.average) begin
                $error("average mismatch: expected %0d, actual %0d",
                       want.average, got.average);
                errors++;
            end
            if (got.tare_updated !== want.tare_updated) begin
                $error("tare_updated mismatch: expected %0d, actual %0d",
                       want.tare_updated, got.tare_updated);
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_TDATA_BITS-1:0]  s_tdata;   // [11:0] sample
    logic                     s_tuser;   // [0] func
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_TDATA_BITS-1:0]  m_tdata;   // [18:0] weight, [30:19] average
    logic                     m_tuser;   // [0] tare_updated
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    window_result_tracker tracker = new();
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;

    load_cell_average_tare_weigh DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog on the whole run.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    // Monitors for both streams, sampled at the clock edge.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            tracker.take_sample(s_tdata[SAMPLE_BITS-1:0], s_tuser);
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result('{weight:       m_tdata[WEIGHT_BITS-1:0],
                                   average:      m_tdata[WEIGHT_BITS +: AVG_BITS],
                                   tare_updated: m_tuser});
    end

    // Result receiver: a random stall before each transaction, with bursts.
    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    // Sends one sample transaction after a random gap.
    task automatic send_sample(logic [SAMPLE_BITS-1:0] sample, logic func);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_BITS'(sample);
        s_tuser  <= func;
        do @(posedge clk); while (!(s_tvalid && s_tready));
    endtask

    // A window of one constant level; only the closing sample's func counts.
    task automatic send_level_window(int level, logic tare);
        for (int i = 0; i < SAMPLES_PER_WINDOW; i++)
            send_sample(SAMPLE_BITS'(level),
                        (i == SAMPLES_PER_WINDOW - 1) ? tare : 1'($urandom_range(0, 1)));
    endtask

    // A window of samples around a random level, sometimes fully random.
    task automatic send_random_window();
        int  base;
        int  spread;
        int  level;
        bit  noisy;
        logic tare;
        base   = $urandom_range(0, 4095);
        spread = $urandom_range(0, 80);
        noisy  = ($urandom_range(0, 4) == 0);
        tare   = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < SAMPLES_PER_WINDOW; i++)
        begin
            if (noisy)
                level = $urandom_range(0, 4095);
            else
                level = base + $urandom_range(0, 2 * spread) - spread;
            if (level < 0)
                level = 0;
            if (level > 4095)
                level = 4095;
            send_sample(SAMPLE_BITS'(level),
                        (i == SAMPLES_PER_WINDOW - 1) ? tare : 1'($urandom_range(0, 1)));
        end
    endtask

    // Stops the sample stream and waits until every window result is out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (tracker.pending_windows.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write: setup cycle, then access cycle.
    task automatic apb_write(reg_index_t idx, logic [APB_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.set_register(idx, value);
    endtask

    task automatic configure(int gain, int offset, int dead, int margin);
        drain_results();
        apb_write(REG_GAIN, gain);
        apb_write(REG_OFFSET, offset);
        apb_write(REG_DEAD_BAND, dead);
        apb_write(REG_TARE_MARGIN, margin);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random register value that favors both ends of the range.
    function automatic int pick_value(int hi);
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return hi;
            default: return $urandom_range(0, hi);
        endcase
    endfunction

    // Main stimulus.
    initial
    begin
        int dead;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        rst_n    <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: tare below zero, full scale, dead band edge, net below tare.
        send_level_window(0, 1'b1);
        send_level_window(4095, 1'b0);
        send_level_window(20, 1'b0);
        send_level_window(21, 1'b0);
        send_level_window(4095, 1'b1);
        send_level_window(100, 1'b0);

        // Zero gain with full offset drives the scaled value negative.
        configure(0, 65535, 0, 255);
        send_level_window(200, 1'b1);
        send_level_window(1, 1'b0);

        // Small negative scaled value shows truncation toward zero.
        configure(1, 15, 0, 0);
        send_level_window(1, 1'b0);

        // Largest gain: net equal to the widest dead band, then no dead band.
        configure(1023, 0, 4095, 0);
        send_level_window(0, 1'b1);
        send_level_window(4095, 1'b0);
        configure(1023, 0, 0, 0);
        send_level_window(4095, 1'b0);

        // Random phases, each under its own register setting.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            dead = ($urandom_range(0, 2) == 0) ? pick_value(4095) : $urandom_range(0, 64);
            configure(pick_value(1023), pick_value(65535), dead, pick_value(255));
            repeat (WINDOWS_PER_PHASE) send_random_window();
        end

        drain_results();
        if (tracker.errors == 0 && tracker.pending_windows.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
